[hdl/link_retry_controller_core_defines.svh]
// assertion macros for the link retry controller
// no dependencies; included by the files that carry assertions
`ifndef LINK_RETRY_CONTROLLER_CORE_DEFINES_SVH
`define LINK_RETRY_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define LRC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link retry controller check failed");

`define LRC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link retry controller check failed");

`else

`define LRC_ASSERT_SAME(name, clk, rst, ante, cons)

`define LRC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[hdl/lrc_pkg.sv]
// shared types and codes for the link retry controller
// no dependencies
package lrc_pkg;

   localparam int OP_W      = 3;
   localparam int ACT_W     = 3;
   localparam int LIMIT_W   = 8;
   localparam int TIMEOUT_W = 16;
   localparam int COUNT_W   = 9;
   localparam int ELAPSED_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [OP_W-1:0] OP_SUBMIT = 3'd0;
   localparam logic [OP_W-1:0] OP_DRAIN  = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
   localparam logic [OP_W-1:0] OP_ACK    = 3'd3;
   localparam logic [OP_W-1:0] OP_NAK    = 3'd4;

   localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FRAME  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ENQ    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_OK     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FAIL   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_REJECT = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NAK_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENQ_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMBEDDED    = 2'd3;

   localparam logic [LIMIT_W-1:0]   NAK_LIMIT_RST   = 8'd3;
   localparam logic [LIMIT_W-1:0]   ENQ_LIMIT_RST   = 8'd3;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd100;

   typedef struct packed {
      logic [LIMIT_W-1:0]   nak_limit;
      logic [LIMIT_W-1:0]   enquiry_limit;
      logic [TIMEOUT_W-1:0] reply_timeout_ticks;
      logic                 embedded_responses;
   } lrc_cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic            receiver_active;
      logic            output_full;
   } lrc_req_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             busy_res;
   } lrc_rsp_type;

endpackage

[hdl/link_retry_controller_core.sv]
// link retry controller: input word register, retry state machine, result register
// depends on lrc_pkg and lrc_ctrl
// an accepted request word is held in the input word register, and its response word in the result register
// throughput: one word per cycle while the response side does not stall
// reset: synchronous, clears valids and retry state, loads register defaults
module link_retry_controller_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [lrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrc_pkg::CSR_DAT_W-1:0]   csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lrc_pkg::OP_W-1:0]        req_operation,
   input  logic                            req_receiver_active,
   input  logic                            req_output_full,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lrc_pkg::ACT_W-1:0]       rsp_action,
   output logic                            rsp_busy_res
);
   import lrc_pkg::*;

   lrc_cfg_type cfg_ff;
   logic        in_valid_ff;
   lrc_req_type in_word_ff;
   logic        out_valid_ff;
   lrc_rsp_type out_word_ff, out_word_in;
   logic        out_hold;
   logic        step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nak_limit           <= NAK_LIMIT_RST;
         cfg_ff.enquiry_limit       <= ENQ_LIMIT_RST;
         cfg_ff.reply_timeout_ticks <= TIMEOUT_RST;
         cfg_ff.embedded_responses  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NAK_LIMIT: cfg_ff.nak_limit           <= csr_data[LIMIT_W-1:0];
            CSR_ENQ_LIMIT: cfg_ff.enquiry_limit       <= csr_data[LIMIT_W-1:0];
            CSR_TIMEOUT:   cfg_ff.reply_timeout_ticks <= csr_data[TIMEOUT_W-1:0];
            CSR_EMBEDDED:  cfg_ff.embedded_responses  <= csr_data[0];
            default:       cfg_ff                     <= cfg_ff;
         endcase
      end
   end

   assign out_hold  = out_valid_ff && rsp_stall;
   assign req_stall = in_valid_ff && out_hold;
   assign step      = in_valid_ff && !out_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_word_ff.operation       <= req_operation;
         in_word_ff.receiver_active <= req_receiver_active;
         in_word_ff.output_full     <= req_output_full;
      end
   end

   lrc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_word_ff),
      .cfg    (cfg_ff),
      .result (out_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_action   = out_word_ff.action;
   assign rsp_busy_res = out_word_ff.busy_res;

endmodule

[hdl/lrc_ctrl.sv]
// retry state machine: phase, nak and enquiry counts, reply timer
// depends on lrc_pkg and link_retry_controller_core_defines.svh
`include "link_retry_controller_core_defines.svh"

module lrc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  lrc_pkg::lrc_req_type word,
   input  lrc_pkg::lrc_cfg_type cfg,
   output lrc_pkg::lrc_rsp_type result
);
   import lrc_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_SENDING = 2'd1;
   localparam logic [1:0] PH_AWAIT   = 2'd2;

   localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   logic [1:0]           phase_ff, phase_in;
   logic [COUNT_W-1:0]   nak_ff, nak_in, nak_inc;
   logic [COUNT_W-1:0]   enq_ff, enq_in, enq_inc;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [ACT_W-1:0]     act;

   assign nak_inc     = (nak_ff == COUNT_MAX) ? nak_ff : nak_ff + COUNT_W'(1);
   assign enq_inc     = (enq_ff == COUNT_MAX) ? enq_ff : enq_ff + COUNT_W'(1);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff
                                                    : elapsed_ff + ELAPSED_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      nak_in     = nak_ff;
      enq_in     = enq_ff;
      elapsed_in = elapsed_ff;
      act        = ACT_NONE;
      case (word.operation)
         OP_SUBMIT: begin
            phase_in = PH_SENDING;
            act      = ACT_FRAME;
            if (word.output_full) begin
               phase_in = PH_IDLE;
               nak_in   = '0;
               enq_in   = '0;
               act      = ACT_FAIL;
            end
         end
         OP_DRAIN: begin
            if (phase_ff == PH_SENDING) begin
               phase_in   = PH_AWAIT;
               elapsed_in = '0;
            end
         end
         OP_TICK: begin
            if ((cfg.embedded_responses || !word.receiver_active) &&
                phase_ff == PH_AWAIT) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc > {1'b0, cfg.reply_timeout_ticks}) begin
                  if (enq_inc > {1'b0, cfg.enquiry_limit} || word.output_full) begin
                     phase_in = PH_IDLE;
                     nak_in   = '0;
                     enq_in   = '0;
                     act      = ACT_FAIL;
                  end else begin
                     phase_in = PH_SENDING;
                     enq_in   = enq_inc;
                     act      = ACT_ENQ;
                  end
               end
            end
         end
         OP_ACK: begin
            if (phase_ff == PH_AWAIT) begin
               phase_in = PH_IDLE;
               nak_in   = '0;
               enq_in   = '0;
               act      = ACT_OK;
            end else begin
               act = ACT_REJECT;
            end
         end
         OP_NAK: begin
            if (phase_ff == PH_AWAIT) begin
               if (nak_inc >= {1'b0, cfg.nak_limit} || word.output_full) begin
                  phase_in = PH_IDLE;
                  nak_in   = '0;
                  enq_in   = '0;
                  act      = ACT_FAIL;
               end else begin
                  phase_in = PH_SENDING;
                  nak_in   = nak_inc;
                  act      = ACT_FRAME;
               end
            end else begin
               act = ACT_REJECT;
            end
         end
         default: begin
            act = ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         nak_ff     <= '0;
         enq_ff     <= '0;
         elapsed_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         nak_ff     <= nak_in;
         enq_ff     <= enq_in;
         elapsed_ff <= elapsed_in;
      end
   end

   assign result.action   = act;
   assign result.busy_res = (phase_in != PH_IDLE);

   `LRC_ASSERT_SAME(a_idle_counts_clear, clock, reset, phase_ff == PH_IDLE,
                    nak_ff == '0 && enq_ff == '0)
   `LRC_ASSERT_SAME(a_counts_bounded, clock, reset, 1'b1,
                    !nak_ff[COUNT_W-1] && !enq_ff[COUNT_W-1])
   `LRC_ASSERT_NEXT(a_ok_goes_idle, clock, reset, step && act == ACT_OK,
                    phase_ff == PH_IDLE)
   `LRC_ASSERT_NEXT(a_reject_keeps_state, clock, reset, step && act == ACT_REJECT,
                    $stable(phase_ff) && $stable(nak_ff) && $stable(enq_ff))

endmodule

[tb/link_retry_checker.sv]
// response checker for link_retry_controller_core: tracks register writes,
// predicts one response word per accepted request word and compares in order
// depends on lrc_pkg
module link_retry_checker import lrc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OP_W-1:0]      req_operation,
   input  logic                 req_receiver_active,
   input  logic                 req_output_full,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [ACT_W-1:0]     rsp_action,
   input  logic                 rsp_busy_res,
   output int                   fail_count,
   output int                   words_in_flight
);

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {
      LINK_IDLE    = 2'd0,
      LINK_SENDING = 2'd1,
      LINK_AWAIT   = 2'd2
   } link_phase_e;

   lrc_cfg_type            cfg;
   link_phase_e            link_phase;
   logic [COUNT_W-1:0]     naks_taken;
   logic [COUNT_W-1:0]     enquiries_sent;
   logic [ELAPSED_W-1:0]   ticks_waited;
   lrc_rsp_type            expected_replies[$];
   int                     mismatch_total = 0;
   int                     pending_total = 0;

   assign fail_count      = mismatch_total;
   assign words_in_flight = pending_total;

   function automatic logic [ACT_W-1:0] close_frame(input logic [ACT_W-1:0] act);
      naks_taken     = '0;
      enquiries_sent = '0;
      link_phase     = LINK_IDLE;
      return act;
   endfunction

   // a frame or enquiry that cannot be queued fails right away
   function automatic logic [ACT_W-1:0] queue_send(input logic full,
                                                   input logic [ACT_W-1:0] act);
      link_phase = LINK_SENDING;
      if (full)
         return close_frame(ACT_FAIL);
      return act;
   endfunction

   function automatic lrc_rsp_type retry_step(input lrc_req_type word);
      lrc_rsp_type      reply;
      logic [ACT_W-1:0] act;
      act = ACT_NONE;
      case (word.operation)
         OP_SUBMIT: begin
            act = queue_send(word.output_full, ACT_FRAME);
         end
         OP_DRAIN: begin
            if (link_phase == LINK_SENDING) begin
               link_phase   = LINK_AWAIT;
               ticks_waited = '0;
            end
         end
         OP_TICK: begin
            if ((cfg.embedded_responses || !word.receiver_active) &&
                link_phase == LINK_AWAIT) begin
               if (ticks_waited != '1)
                  ticks_waited = ticks_waited + 1'b1;
               if (ticks_waited > {1'b0, cfg.reply_timeout_ticks}) begin
                  if (enquiries_sent != '1)
                     enquiries_sent = enquiries_sent + 1'b1;
                  if (enquiries_sent > {1'b0, cfg.enquiry_limit})
                     act = close_frame(ACT_FAIL);
                  else
                     act = queue_send(word.output_full, ACT_ENQ);
               end
            end
         end
         OP_ACK: begin
            if (link_phase == LINK_AWAIT)
               act = close_frame(ACT_OK);
            else
               act = ACT_REJECT;
         end
         OP_NAK: begin
            if (link_phase == LINK_AWAIT) begin
               if (naks_taken != '1)
                  naks_taken = naks_taken + 1'b1;
               if (naks_taken >= {1'b0, cfg.nak_limit})
                  act = close_frame(ACT_FAIL);
               else
                  act = queue_send(word.output_full, ACT_FRAME);
            end else begin
               act = ACT_REJECT;
            end
         end
         default: begin
         end
      endcase
      reply.action   = act;
      reply.busy_res = (link_phase != LINK_IDLE);
      return reply;
   endfunction

   always @(posedge clock) begin
      lrc_req_type word_in;
      lrc_rsp_type want;
      if (reset) begin
         cfg.nak_limit           = NAK_LIMIT_RST;
         cfg.enquiry_limit       = ENQ_LIMIT_RST;
         cfg.reply_timeout_ticks = TIMEOUT_RST;
         cfg.embedded_responses  = 1'b0;
         link_phase              = LINK_IDLE;
         naks_taken              = '0;
         enquiries_sent          = '0;
         ticks_waited            = '0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT)
                  $display("unexpected response word: action %0d busy %0b",
                           rsp_action, rsp_busy_res);
            end else begin
               want = expected_replies.pop_front();
               if (want.action !== rsp_action || want.busy_res !== rsp_busy_res) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT)
                     $display("mismatch: expected action %0d busy %0b, got action %0d busy %0b",
                              want.action, want.busy_res, rsp_action, rsp_busy_res);
               end
            end
         end
         if (req_valid && !req_stall) begin
            word_in = {req_operation, req_receiver_active, req_output_full};
            expected_replies.push_back(retry_step(word_in));
         end
         if (csr_write) begin
            case (csr_index)
               CSR_NAK_LIMIT: cfg.nak_limit           = csr_data[LIMIT_W-1:0];
               CSR_ENQ_LIMIT: cfg.enquiry_limit       = csr_data[LIMIT_W-1:0];
               CSR_TIMEOUT:   cfg.reply_timeout_ticks = csr_data[TIMEOUT_W-1:0];
               CSR_EMBEDDED:  cfg.embedded_responses  = csr_data[0];
               default: begin
               end
            endcase
         end
      end
      pending_total = expected_replies.size();
   end

endmodule

[tb/tb_link_retry_controller_core.sv]
// top of the link retry controller bench: clock, reset, register writes,
// request words with random gaps, response stalls and the verdict
// depends on lrc_pkg, link_retry_controller_core and link_retry_checker
module tb_link_retry_controller_core;
   import lrc_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int SETTLE_CYCLES = 4;
   localparam int FLUSH_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_ROUNDS = 6;
   localparam int ROUND_WORDS   = 70;
   localparam int LONG_TICKS    = 16;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation;
   logic                 req_receiver_active;
   logic                 req_output_full;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ACT_W-1:0]     rsp_action;
   logic                 rsp_busy_res;
   int                   fail_count;
   int                   words_in_flight;

   int cycle_count = 0;
   int words_sent  = 0;
   int reply_wait  = int'(TIMEOUT_RST);
   bit calm        = 1'b0;
   bit hold_wanted = 1'b0;
   bit hold_done   = 1'b0;

   link_retry_controller_core u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_receiver_active (req_receiver_active),
      .req_output_full     (req_output_full),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_busy_res        (rsp_busy_res)
   );

   link_retry_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_receiver_active (req_receiver_active),
      .req_output_full     (req_output_full),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_busy_res        (rsp_busy_res),
      .fail_count          (fail_count),
      .words_in_flight     (words_in_flight)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      int held;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end else begin
            rsp_stall <= !calm && chance(15);
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic rx, input logic full);
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_receiver_active <= rx;
      req_output_full     <= full;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
      if (!calm && chance(15)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle_link();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (words_in_flight != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DAT_W'(value);
      @(posedge clock);
   endtask

   task automatic load_registers(input int nak, input int enq, input int tmo, input int emb);
      settle_link();
      write_csr(CSR_NAK_LIMIT, nak);
      write_csr(CSR_ENQ_LIMIT, enq);
      write_csr(CSR_TIMEOUT, tmo);
      write_csr(CSR_EMBEDDED, emb);
      csr_write <= 1'b0;
      @(posedge clock);
      reply_wait = tmo;
   endtask

   task automatic noise_word();
      send_word(OP_W'($urandom_range(0, OP_SPARE_LAST)), coin(), coin());
   endtask

   // submit, drain, then replies and timeouts until an ack or the rounds run out
   task automatic frame_exchange();
      int rounds;
      int pick;
      int ticks;
      bit acked;
      acked = 1'b0;
      send_word(OP_SUBMIT, coin(), chance(5));
      send_word(OP_DRAIN, coin(), chance(10));
      rounds = $urandom_range(1, 6);
      for (int r = 0; r < rounds && !acked; r++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            ticks = $urandom_range(0, (reply_wait < 20 ? reply_wait : 20) + 2);
            repeat (ticks) send_word(OP_TICK, chance(25), chance(8));
            send_word(OP_DRAIN, coin(), chance(10));
         end else if (pick < 75) begin
            send_word(OP_NAK, coin(), chance(8));
            send_word(OP_DRAIN, coin(), chance(10));
         end else if (pick < 85) begin
            send_word(OP_ACK, coin(), chance(10));
            acked = 1'b1;
         end else if (pick < 92) begin
            send_word(OP_SUBMIT, coin(), chance(5));
         end else begin
            noise_word();
         end
      end
      if (!acked && chance(70))
         send_word(OP_ACK, coin(), chance(10));
   endtask

   initial begin
      int round_end;
      csr_write           <= 1'b0;
      csr_index           <= CSR_NAK_LIMIT;
      csr_data            <= '0;
      req_valid           <= 1'b0;
      req_operation       <= OP_SUBMIT;
      req_receiver_active <= 1'b0;
      req_output_full     <= 1'b0;
      reset               <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // replies and drains outside their phase, spare codes, full buffer
      send_word(OP_ACK, 1'b0, 1'b0);
      send_word(OP_NAK, 1'b1, 1'b1);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b1);
      for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
         send_word(OP_W'(op), 1'b1, 1'b1);
      send_word(OP_SUBMIT, 1'b0, 1'b1);
      send_word(OP_SUBMIT, 1'b1, 1'b0);
      send_word(OP_ACK, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b1, 1'b0);
      send_word(OP_NAK, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b1, 1'b0);
      send_word(OP_NAK, 1'b0, 1'b1);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      send_word(OP_ACK, 1'b1, 1'b0);

      // enquiry path: full buffer at the enquiry, then limit passed
      load_registers(1, 1, 1, 1);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b1, 1'b0);
      send_word(OP_TICK, 1'b0, 1'b1);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      repeat (2) send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      repeat (2) send_word(OP_TICK, 1'b1, 1'b0);

      // nak count up to the largest limit, zero enquiries allowed
      load_registers(255, 0, 0, 1);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      repeat (254) begin
         send_word(OP_NAK, coin(), 1'b0);
         send_word(OP_DRAIN, coin(), coin());
      end
      send_word(OP_NAK, 1'b0, 1'b0);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      send_word(OP_TICK, 1'b1, 1'b0);

      // enquiry count up to the largest limit, nak limit zero
      load_registers(0, 255, 0, 0);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      repeat (255) begin
         send_word(OP_TICK, 1'b0, 1'b0);
         send_word(OP_DRAIN, coin(), coin());
      end
      send_word(OP_TICK, 1'b0, 1'b0);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      send_word(OP_NAK, 1'b0, 1'b0);

      // longest reply timeout
      load_registers(0, 255, 65535, 1);
      send_word(OP_SUBMIT, 1'b0, 1'b0);
      send_word(OP_DRAIN, 1'b0, 1'b0);
      repeat (LONG_TICKS) send_word(OP_TICK, coin(), 1'b0);
      send_word(OP_TICK, 1'b1, 1'b0);
      send_word(OP_ACK, 1'b0, 1'b0);

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         if (round == RANDOM_ROUNDS - 1)
            load_registers($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 65535), $urandom_range(0, 1));
         else
            load_registers($urandom_range(0, 5), $urandom_range(0, 4),
                           $urandom_range(0, 8), $urandom_range(0, 1));
         calm = (round == 2);
         round_end = words_sent + ROUND_WORDS;
         while (words_sent < round_end) begin
            if (round == 1 && !hold_done && round_end - words_sent <= ROUND_WORDS / 2) begin
               hold_wanted = 1'b1;
               hold_done   = 1'b1;
            end
            if (chance(85))
               frame_exchange();
            else
               noise_word();
         end
      end
      calm = 1'b0;

      settle_link();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_in_flight == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
